// File: design/mtd_pkg.sv
`timescale 1ns / 1ps
// shared types, character codes and lookup functions for the mime transfer decoder
package mtd_pkg;

	localparam int MaxResults = 5;
	localparam int CntW = $clog2(MaxResults + 1);
	localparam int IdxW = $clog2(MaxResults);

	localparam logic [7:0] CharEq = 8'h3D;
	localparam logic [7:0] CharUs = 8'h5F;
	localparam logic [7:0] CharSp = 8'h20;
	localparam logic [7:0] CharCr = 8'h0D;
	localparam logic [7:0] CharLf = 8'h0A;

	typedef enum logic [1:0] {
		ModePass = 2'd0,
		ModeB64  = 2'd1,
		ModeQp   = 2'd2,
		ModeQ    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		QpIdle = 2'd0,
		QpEq   = 2'd1,
		QpHeld = 2'd2
	} qp_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] idx;
	} b64_t;

	typedef struct packed {
		qp_phase_t  phase;
		logic [7:0] held;
		logic       emit;
		logic [7:0] data;
	} qp_step_t;

	function automatic hex_t hex_lookup(input logic [7:0] c);
		hex_t r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.ok = 1'b1;
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.ok = 1'b1;
			r.val = 4'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.ok = 1'b1;
			r.val = 4'(c - 8'h41 + 8'd10);
		end
		return r;
	endfunction

	function automatic b64_t b64_lookup(input logic [7:0] c);
		b64_t r;
		r = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.ok = 1'b1;
			r.idx = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.ok = 1'b1;
			r.idx = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.ok = 1'b1;
			r.idx = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.ok = 1'b1;
			r.idx = 6'd62;
		end else if (c == 8'h2F) begin
			r.ok = 1'b1;
			r.idx = 6'd63;
		end
		return r;
	endfunction

	// one byte from idle or '=' pending
	function automatic qp_step_t qp_simple(input qp_phase_t ph, input logic [7:0] held,
		input logic [7:0] c);
		qp_step_t r;
		r.phase = ph;
		r.held = held;
		r.emit = 1'b0;
		r.data = c;
		if (ph == QpIdle) begin
			if (c == CharEq) r.phase = QpEq;
			else r.emit = 1'b1;
		end else begin
			if (c == CharLf) begin
				r.phase = QpIdle;
			end else begin
				r.held = c;
				r.phase = QpHeld;
			end
		end
		return r;
	endfunction

endpackage

// File: design/mime_transfer_decoder_core.sv
`timescale 1ns / 1ps
// Streaming MIME body decoder: pass-through, base64, quoted-printable or header Q.
// Input items (s_tvalid/s_tready) carry one raw body byte in s_tdata and the
// end-of-body mark in s_tlast. Result items (m_tvalid/m_tready) carry a decoded
// byte in m_tdata, a data flag in m_tuser (0 on an end-only item) and m_tlast on
// the final item of the body. cfg_valid/cfg_data writes the two-bit mode; it is
// always ready, and the user must see that it is written only between bodies
// while the decoder is empty; the block itself does not enforce this. An
// accepted item waits in the input register, then its results (zero to three)
// are loaded together into the result buffer, where the first result item is
// valid as soon as it is loaded. With the receiver ready, items with at most one
// result each run at one item per cycle; an item with k results holds the next
// item in the input register while the buffer drains, one result per cycle while
// m_tready is high. When the receiver stalls the buffer holds its items and the
// input side stops once the input register is full. Reset clears the mode to
// pass-through, all decoder state and both pipeline stages, dropping any item in flight.
module mime_transfer_decoder_core import mtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tuser,   // has_byte
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data   // transfer_mode
);

	mode_t                 mode_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  can_load;
	logic                  load;
	res_t [MaxResults-1:0] res;
	logic [CntW-1:0]       res_cnt;

	assign cfg_ready = 1'b1;
	assign load = valid_s1 && can_load;
	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModePass;
		end else if (cfg_valid) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mtd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.load    (load),
		.res     (res),
		.res_cnt (res_cnt)
	);

	mtd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.res_cnt  (res_cnt),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_load_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> valid_s1 && can_load)
		else $error("load without a held item");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register changed while stalled");

	a_end_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'h00)
		else $error("end-only item without end mark");

endmodule

// File: design/mtd_decode.sv
`timescale 1ns / 1ps
// per-item decode logic and the decoder state registers
module mtd_decode import mtd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mode_t                     mode,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	input  logic                      load,
	output res_t [MaxResults-1:0]     res,
	output logic [CntW-1:0]           res_cnt
);

	qp_phase_t   qp_phase_q;
	logic [7:0]  qp_held_q;
	logic [11:0] b64_acc_q;
	logic [2:0]  b64_cnt_q;
	logic        b64_stop_q;

	qp_phase_t   ph_d;
	logic [7:0]  held_d;
	logic [11:0] acc_d;
	logic [2:0]  bc_d;
	logic        stop_d;

	always_comb begin
		logic [7:0]      c;
		logic [7:0]      h;
		logic [CntW-1:0] cnt;
		logic [CntW-1:0] prev;
		logic [3:0]      sum;
		logic [11:0]     shifted;
		b64_t            b;
		hex_t            hh;
		hex_t            hl;
		qp_step_t        st;
		logic            crlf_brk;

		c = in_byte;
		h = qp_held_q;
		ph_d = qp_phase_q;
		held_d = qp_held_q;
		acc_d = b64_acc_q;
		bc_d = b64_cnt_q;
		stop_d = b64_stop_q;
		cnt = '0;
		prev = '0;
		sum = '0;
		shifted = '0;
		b = '0;
		hh = '0;
		hl = '0;
		st = '0;
		crlf_brk = 1'b0;
		res = '0;

		case (mode)
			ModePass: begin
				res[cnt[IdxW-1:0]] = '{data: c, has: 1'b1, last: 1'b0};
				cnt = cnt + CntW'(1);
			end
			ModeB64: begin
				if (!stop_d) begin
					if (c == CharEq) begin
						stop_d = 1'b1;
					end else begin
						b = b64_lookup(c);
						if (b.ok) begin
							acc_d = {acc_d[5:0], b.idx};
							sum = {1'b0, bc_d} + 4'd6;
							if (sum >= 4'd8) begin
								shifted = acc_d >> (sum - 4'd8);
								res[cnt[IdxW-1:0]] = '{data: shifted[7:0], has: 1'b1,
									last: 1'b0};
								cnt = cnt + CntW'(1);
								sum = sum - 4'd8;
							end
							bc_d = sum[2:0];
						end
					end
				end
			end
			default: begin
				if (mode == ModeQ && c == CharUs) c = CharSp;
				if (ph_d != QpHeld) begin
					st = qp_simple(ph_d, held_d, c);
					ph_d = st.phase;
					held_d = st.held;
					if (st.emit) begin
						res[cnt[IdxW-1:0]] = '{data: st.data, has: 1'b1, last: 1'b0};
						cnt = cnt + CntW'(1);
					end
				end else begin
					ph_d = QpIdle;
					crlf_brk = (h == CharCr) && (c == CharLf);
					hh = hex_lookup(h);
					hl = hex_lookup(c);
					if (!crlf_brk) begin
						if (hh.ok && hl.ok) begin
							res[cnt[IdxW-1:0]] = '{data: {hh.val, hl.val}, has: 1'b1,
								last: 1'b0};
							cnt = cnt + CntW'(1);
						end else begin
							// broken escape: literal '=' then replay both bytes
							res[cnt[IdxW-1:0]] = '{data: CharEq, has: 1'b1, last: 1'b0};
							cnt = cnt + CntW'(1);
							st = qp_simple(ph_d, held_d, h);
							ph_d = st.phase;
							held_d = st.held;
							if (st.emit) begin
								res[cnt[IdxW-1:0]] = '{data: st.data, has: 1'b1,
									last: 1'b0};
								cnt = cnt + CntW'(1);
							end
							st = qp_simple(ph_d, held_d, c);
							ph_d = st.phase;
							held_d = st.held;
							if (st.emit) begin
								res[cnt[IdxW-1:0]] = '{data: st.data, has: 1'b1,
									last: 1'b0};
								cnt = cnt + CntW'(1);
							end
						end
					end
				end
				if (in_last) begin
					if (ph_d != QpIdle) begin
						res[cnt[IdxW-1:0]] = '{data: CharEq, has: 1'b1, last: 1'b0};
						cnt = cnt + CntW'(1);
					end
					if (ph_d == QpHeld) begin
						res[cnt[IdxW-1:0]] = '{data: held_d, has: 1'b1, last: 1'b0};
						cnt = cnt + CntW'(1);
					end
					ph_d = QpIdle;
				end
			end
		endcase

		if (in_last) begin
			if (cnt == '0) begin
				res[0] = '{data: 8'h00, has: 1'b0, last: 1'b1};
				cnt = CntW'(1);
			end else begin
				prev = cnt - CntW'(1);
				res[prev[IdxW-1:0]].last = 1'b1;
			end
			ph_d = QpIdle;
			held_d = '0;
			acc_d = '0;
			bc_d = '0;
			stop_d = 1'b0;
		end
		res_cnt = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qp_phase_q <= QpIdle;
			qp_held_q <= '0;
			b64_acc_q <= '0;
			b64_cnt_q <= '0;
			b64_stop_q <= 1'b0;
		end else if (load) begin
			qp_phase_q <= ph_d;
			qp_held_q <= held_d;
			b64_acc_q <= acc_d;
			b64_cnt_q <= bc_d;
			b64_stop_q <= stop_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load && in_last |=> qp_phase_q == QpIdle && b64_cnt_q == '0 && !b64_stop_q)
		else $error("state not cleared after end of body");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		load && in_last |-> res_cnt != '0 && res_cnt <= CntW'(MaxResults))
		else $error("end of body without a result item");

	a_b64_even: assert property (@(posedge clk) disable iff (!arst_n)
		b64_cnt_q[0] == 1'b0)
		else $error("odd base64 bit count");

endmodule

// File: design/mtd_out_buf.sv
`timescale 1ns / 1ps
// result buffer that hands out the result items of one input item in order
module mtd_out_buf import mtd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  res_t [MaxResults-1:0] res,
	input  logic [CntW-1:0]       res_cnt,
	output logic                  can_load,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // out_byte
	output logic                  m_tuser,   // has_byte
	output logic                  m_tlast
);

	res_t [MaxResults-1:0] ent_q;
	logic [CntW-1:0]       cnt_q;
	logic [CntW-1:0]       rd_q;
	logic [CntW-1:0]       rd_nx;
	res_t                  cur;

	assign rd_nx = rd_q + CntW'(1);
	assign m_tvalid = (rd_q != cnt_q);
	assign cur = ent_q[rd_q[IdxW-1:0]];
	assign m_tdata = cur.data;
	assign m_tuser = cur.has;
	assign m_tlast = cur.last;
	// refill when empty or when the last held item leaves this cycle
	assign can_load = !m_tvalid || (rd_nx == cnt_q && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else if (load) begin
			cnt_q <= res_cnt;
			rd_q <= '0;
		end else if (m_tvalid && m_tready) begin
			rd_q <= rd_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load) ent_q <= res;
	end

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q && cnt_q <= CntW'(MaxResults))
		else $error("read pointer past fill count");

	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> rd_nx == cnt_q)
		else $error("last item not at end of buffer");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rd_q == '0)
		else $error("buffer load did not restart pointer");

endmodule

// File: dv/mtd_decode_monitor.sv
`timescale 1ns / 1ps
// watches the decoder's channels, predicts every decoded item and compares the results
module mtd_decode_monitor import mtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // out_byte
	input  logic       m_tuser,   // has_byte
	input  logic       m_tlast,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_data,  // transfer_mode
	output int         pending,
	output int         fail_count,
	output int         results_seen
);

	mode_t      mode;
	qp_phase_t  qp_ph;
	logic [7:0] qp_hold;
	logic [11:0] b64_acc;
	logic [2:0] b64_cnt;
	logic       b64_halt;
	res_t       step_res[$];
	res_t       expected_bytes[$];
	res_t       want;

	function automatic int sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - 65;
		if (c >= "a" && c <= "z") return int'(c) - 97 + 26;
		if (c >= "0" && c <= "9") return int'(c) - 48 + 52;
		if (c == "+") return 62;
		if (c == "/") return 63;
		return -1;
	endfunction

	function automatic int nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 48;
		if (c >= "a" && c <= "f") return int'(c) - 97 + 10;
		if (c >= "A" && c <= "F") return int'(c) - 65 + 10;
		return -1;
	endfunction

	task automatic emit(input logic [7:0] v);
		res_t r;
		r.data = v;
		r.has = 1'b1;
		r.last = 1'b0;
		step_res.insert(step_res.size(), r);
	endtask

	task automatic clear_decoder();
		qp_ph = QpIdle;
		qp_hold = '0;
		b64_acc = '0;
		b64_cnt = '0;
		b64_halt = 1'b0;
	endtask

	task automatic b64_take(input logic [7:0] c);
		int idx;
		logic [3:0] cnt;
		idx = sextet(c);
		if (b64_halt) return;
		if (c == CharEq) begin
			b64_halt = 1'b1;
			return;
		end
		if (idx < 0) return;
		b64_acc = {b64_acc[5:0], idx[5:0]};
		cnt = {1'b0, b64_cnt} + 4'd6;
		if (cnt >= 4'd8) begin
			emit(8'(b64_acc >> (cnt - 4'd8)));
			cnt = cnt - 4'd8;
		end
		b64_cnt = cnt[2:0];
	endtask

	// idle or '=' pending
	task automatic qp_plain(input logic [7:0] c);
		if (qp_ph == QpIdle) begin
			if (c == CharEq) qp_ph = QpEq;
			else emit(c);
		end else if (c == CharLf) begin
			qp_ph = QpIdle;
		end else begin
			qp_hold = c;
			qp_ph = QpHeld;
		end
	endtask

	task automatic qp_take(input logic [7:0] c);
		logic [7:0] h;
		int hi;
		int lo;
		if (qp_ph != QpHeld) begin
			qp_plain(c);
			return;
		end
		h = qp_hold;
		qp_ph = QpIdle;
		if (h == CharCr && c == CharLf) return;
		hi = nibble(h);
		lo = nibble(c);
		if (hi >= 0 && lo >= 0) begin
			emit(8'((hi << 4) | lo));
			return;
		end
		// broken escape: literal '=' then replay the held byte from idle and the new byte after it
		emit(CharEq);
		qp_plain(h);
		qp_plain(c);
	endtask

	task automatic predict_decode(input logic [7:0] c, input logic last);
		logic [7:0] b;
		res_t tail;
		step_res.delete();
		b = c;
		case (mode)
			ModePass: begin
				emit(b);
			end
			ModeB64: begin
				b64_take(b);
			end
			default: begin
				if (mode == ModeQ && b == CharUs) b = CharSp;
				qp_take(b);
				if (last) begin
					if (qp_ph == QpEq || qp_ph == QpHeld) emit(CharEq);
					if (qp_ph == QpHeld) emit(qp_hold);
					qp_ph = QpIdle;
				end
			end
		endcase
		if (last) begin
			if (step_res.size() == 0) begin
				tail = '0;
			end else begin
				tail = step_res[step_res.size() - 1];
				step_res.delete(step_res.size() - 1);
			end
			tail.last = 1'b1;
			step_res.insert(step_res.size(), tail);
			clear_decoder();
		end
		foreach (step_res[i]) expected_bytes.insert(expected_bytes.size(), step_res[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = ModePass;
			clear_decoder();
			expected_bytes.delete();
			pending = 0;
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) mode = mode_t'(cfg_data);
			if (s_tvalid && s_tready) predict_decode(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_bytes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected item, expected nothing, got data %02h flag %0b last %0b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = expected_bytes.pop_front();
					if (want.data !== m_tdata || want.has !== m_tuser || want.last !== m_tlast) begin
						fail_count++;
						$display("%0t: expected data %02h flag %0b last %0b, got data %02h flag %0b last %0b",
							$time, want.data, want.has, want.last, m_tdata, m_tuser, m_tlast);
					end
				end
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// File: dv/mime_transfer_decoder_core_tb.sv
`timescale 1ns / 1ps
// top of the decoder testbench: clock, reset, body stimulus, result stalls and verdict
module mime_transfer_decoder_core_tb import mtd_pkg::*; ();

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;   // in_byte
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;        // out_byte
	logic       m_tuser;        // has_byte
	logic       m_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = '0;  // transfer_mode

	int         pending;
	int         fail_count;
	int         results_seen;
	int         bodies;
	int         bytes_sent;
	bit         calm;
	logic [7:0] body[$];

	mime_transfer_decoder_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	mtd_decode_monitor monitor (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.pending(pending), .fail_count(fail_count), .results_seen(results_seen)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver stalls a random number of cycles before each item
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_body();
		foreach (body[i]) send_byte(body[i], i == body.size() - 1);
		body.delete();
		bodies++;
	endtask

	task automatic add_byte(input logic [7:0] v);
		body.insert(body.size(), v);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	// mode changes only once the decoder has drained
	task automatic set_mode(input mode_t m);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] b64_char(input int idx);
		if (idx < 26) return 8'(65 + idx);
		if (idx < 52) return 8'(97 + idx - 26);
		if (idx < 62) return 8'(48 + idx - 52);
		return (idx == 62) ? 8'h2B : 8'h2F;
	endfunction

	function automatic logic [7:0] hex_char(input int v);
		if (v < 10) return 8'(48 + v);
		return ($urandom_range(0, 1) != 0) ? 8'(65 + v - 10) : 8'(97 + v - 10);
	endfunction

	initial begin
		mode_t m;
		int len;
		int r;
		bodies = 0;
		bytes_sent = 0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through at reset mode, byte extremes
		add_byte(8'h00);
		add_byte(8'hFF);
		send_body();
		// "Man", a six-bit leftover, a dropped byte, stop at '=', ignored tail
		set_mode(ModeB64);
		add_text("TWFu/!=A");
		send_body();
		// hex escape, both soft breaks, broken escape, escape still open at end
		set_mode(ModeQp);
		add_text("=41=\r\n=\n=G1=Z");
		send_body();
		set_mode(ModeQ);
		add_text("_=5F");
		send_body();

		while (bytes_sent < 175) begin
			m = mode_t'($urandom_range(0, 3));
			set_mode(m);
			calm = ($urandom_range(0, 3) == 0);
			len = $urandom_range(1, 12);
			case (m)
				ModePass: begin
					repeat (len) add_byte(8'($urandom_range(0, 255)));
				end
				ModeB64: begin
					repeat (len) begin
						r = $urandom_range(0, 19);
						if (r < 16) add_byte(b64_char($urandom_range(0, 63)));
						else if (r < 18) add_byte(8'($urandom_range(0, 255)));
						else if (r == 18) add_byte(CharEq);
						else add_byte(CharLf);
					end
				end
				default: begin
					while (body.size() < len) begin
						r = $urandom_range(0, 19);
						if (r < 8) begin
							add_byte(8'($urandom_range(32, 126)));
						end else if (r < 13) begin
							add_byte(CharEq);
							add_byte(hex_char($urandom_range(0, 15)));
							add_byte(hex_char($urandom_range(0, 15)));
						end else if (r < 15) begin
							add_byte(CharEq);
							if ($urandom_range(0, 1) != 0) add_byte(CharCr);
							add_byte(CharLf);
						end else if (r < 17) begin
							add_byte(CharEq);
							add_byte(8'($urandom_range(0, 255)));
							add_byte(8'($urandom_range(0, 255)));
						end else if (r == 17) begin
							add_byte(CharUs);
						end else begin
							add_byte(8'($urandom_range(0, 255)));
						end
					end
				end
			endcase
			send_body();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("run: %0d bodies, %0d input bytes, %0d decoded items checked", bodies,
			bytes_sent, results_seen);
		$display("modes: pass-through, base64, quoted-printable and header Q with random stalls");
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
